>>> design/afsk_pkg.sv
package afsk_pkg;

   // Fixed geometry of the tone generator
   localparam int TABLE_DEPTH   = 512;
   localparam int ADDR_BITS     = $clog2(TABLE_DEPTH);
   localparam int SAMPLE_BITS   = 12;
   localparam int FRACTION_BITS = 20;
   localparam int PHASE_BITS    = 32;
   localparam int SPB_BITS      = 7;

   localparam logic [SPB_BITS-1:0] MAX_SPB = 7'd64;

   // Register reset values
   localparam logic [PHASE_BITS-1:0]  MARK_INC_RESET  = 32'd26843545;
   localparam logic [PHASE_BITS-1:0]  SPACE_INC_RESET = 32'd49073355;
   localparam logic [SPB_BITS-1:0]    SPB_RESET       = 7'd20;

   // Pre-emphasis offset added to halved mark samples
   localparam logic [SAMPLE_BITS-1:0] EMPH_OFFSET = 12'd64;

   // Q28 constants for the table build
   localparam logic [63:0] PI_Q28  = 64'd843314857;
   localparam logic [63:0] ONE_Q28 = 64'd268435456;

   typedef enum logic [1:0] {
      CSR_MARK_INC  = 2'd0,
      CSR_SPACE_INC = 2'd1,
      CSR_SPB       = 2'd2,
      CSR_EMPH      = 2'd3
   } csr_index_type;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [TABLE_DEPTH-1:0][SAMPLE_BITS-1:0] sine_table_type;

   // Odd Taylor terms subtract, clamped at zero
   function automatic logic [63:0] sub_clamp(input logic [63:0] a, input logic [63:0] b);
      sub_clamp = (a >= b) ? (a - b) : 64'd0;
   endfunction

   // sin(x) for x in [0, pi/2], Q28 in and out, Taylor series to x^15
   function automatic logic [63:0] sin_q28(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x2   = (x * x) >> 28;
      term = x;
      sum  = x;
      term = ((term * x2) >> 28) / 64'd6;
      sum  = sub_clamp(sum, term);
      term = ((term * x2) >> 28) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 28) / 64'd42;
      sum  = sub_clamp(sum, term);
      term = ((term * x2) >> 28) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 28) / 64'd110;
      sum  = sub_clamp(sum, term);
      term = ((term * x2) >> 28) / 64'd156;
      sum  = sum + term;
      term = ((term * x2) >> 28) / 64'd210;
      sum  = sub_clamp(sum, term);
      if (sum > ONE_Q28) begin
         sum = ONE_Q28;
      end
      sin_q28 = sum;
   endfunction

   // Offset sine table, evaluated at elaboration
   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      logic [63:0]    full;
      logic [63:0]    a;
      logic [63:0]    s;
      logic [63:0]    u;
      logic [63:0]    r;
      logic           neg;
      full = (64'd1 << SAMPLE_BITS) - 64'd1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         a   = (64'd2 * PI_Q28 * 64'(i)) / TABLE_DEPTH;
         neg = 1'b0;
         if (a > PI_Q28) begin
            neg = 1'b1;
            a   = a - PI_Q28;
         end
         if (a > (PI_Q28 >> 1)) begin
            a = (a >= PI_Q28) ? 64'd0 : (PI_Q28 - a);
         end
         s = sin_q28(a);
         u = neg ? (ONE_Q28 - s) : (ONE_Q28 + s);
         r = (full * u + ONE_Q28) >> 29;
         tbl[i] = r[SAMPLE_BITS-1:0];
      end
      build_sine_table = tbl;
   endfunction

endpackage

>>> design/afsk_nrzi_tone_modulator_unit.sv
// Channel   Direction  Handshake          Word
// req_      in         req_valid/stall    one data bit plus restart flag
// rsp_      out        rsp_valid/stall    one DAC sample plus last-of-bit flag
// csr_      in         csr_write_enable   register index and 32-bit data
//
// Each bit yields samples_per_bit samples (1 to 64, zero counts as one), one
// sample per cycle from the phase accumulator unless rsp_ stalls; the next bit
// is taken in the cycle of the last sample. An accepted bit's samples pass
// the generator state, phase stage and result register. Reset is synchronous
// and clears phase, tone and registers to defaults. A stall on rsp_ freezes the
// whole sample path; a new bit is then held off unless the generator is idle.
module afsk_nrzi_tone_modulator_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_data_bit,
   input  logic                 req_restart,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output afsk_pkg::sample_type rsp_sample,
   output logic                 rsp_last_of_bit,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_write_data
);

   localparam int PB  = afsk_pkg::PHASE_BITS;
   localparam int FB  = afsk_pkg::FRACTION_BITS;
   localparam int AB  = afsk_pkg::ADDR_BITS;
   localparam int SB  = afsk_pkg::SPB_BITS;

   // Configuration registers
   logic [PB-1:0] mark_inc_ff;
   logic [PB-1:0] space_inc_ff;
   logic [SB-1:0] spb_ff;
   logic          emph_ff;

   // Sample generator state
   logic          busy_ff, busy_in;
   logic [SB-1:0] remain_ff, remain_in;
   logic          tone_ff, tone_in;
   logic [PB-1:0] phase_ff, phase_in;

   // Phase stage
   logic          a_valid_ff;
   logic [AB-1:0] a_index_ff;
   logic          a_mark_ff;
   logic          a_last_ff;

   // Result stage
   logic                 rsp_valid_ff;
   afsk_pkg::sample_type rsp_sample_ff;
   logic                 rsp_last_ff;

   logic                 advance;
   logic                 gen;
   logic                 accept;
   logic [PB-1:0]        phase_sum;
   logic [SB-1:0]        count;
   afsk_pkg::sample_type shaped;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mark_inc_ff  <= afsk_pkg::MARK_INC_RESET;
         space_inc_ff <= afsk_pkg::SPACE_INC_RESET;
         spb_ff       <= afsk_pkg::SPB_RESET;
         emph_ff      <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (afsk_pkg::csr_index_type'(csr_index))
            afsk_pkg::CSR_MARK_INC:  mark_inc_ff  <= csr_write_data;
            afsk_pkg::CSR_SPACE_INC: space_inc_ff <= csr_write_data;
            afsk_pkg::CSR_SPB:       spb_ff       <= csr_write_data[SB-1:0];
            afsk_pkg::CSR_EMPH:      emph_ff      <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Clamp the sample count to 1..64
   always_comb begin
      if (spb_ff == '0) begin
         count = SB'(1);
      end else if (spb_ff > afsk_pkg::MAX_SPB) begin
         count = afsk_pkg::MAX_SPB;
      end else begin
         count = spb_ff;
      end
   end

   // Pipeline moves as a whole unless the result is held
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign gen       = busy_ff && advance;
   assign req_stall = busy_ff && !(advance && (remain_ff == SB'(1)));
   assign accept    = req_valid && !req_stall;
   assign phase_sum = phase_ff + (tone_ff ? space_inc_ff : mark_inc_ff);

   // Advance the phase, count samples, take the next bit
   always_comb begin
      busy_in   = busy_ff;
      remain_in = remain_ff;
      tone_in   = tone_ff;
      phase_in  = phase_ff;
      if (gen) begin
         phase_in  = phase_sum;
         remain_in = remain_ff - SB'(1);
         if (remain_ff == SB'(1)) begin
            busy_in = 1'b0;
         end
      end
      if (accept) begin
         busy_in   = 1'b1;
         remain_in = count;
         tone_in   = (req_restart ? 1'b0 : tone_ff) ^ !req_data_bit;
         if (req_restart) begin
            phase_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         remain_ff <= '0;
         tone_ff   <= 1'b0;
         phase_ff  <= '0;
      end else begin
         busy_ff   <= busy_in;
         remain_ff <= remain_in;
         tone_ff   <= tone_in;
         phase_ff  <= phase_in;
      end
   end

   // Register the table address of the new sample
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= gen;
      end
   end

   always_ff @(posedge clock) begin
      if (gen) begin
         a_index_ff <= phase_sum[FB+AB-1:FB];
         a_mark_ff  <= !tone_ff;
         a_last_ff  <= (remain_ff == SB'(1));
      end
   end

   afsk_tone_shaper u_shaper (
      .index     (a_index_ff),
      .emphasize (emph_ff && a_mark_ff),
      .sample    (shaped)
   );

   // Load the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && a_valid_ff) begin
         rsp_sample_ff <= shaped;
         rsp_last_ff   <= a_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;
   assign rsp_last_of_bit = rsp_last_ff;

endmodule

>>> design/afsk_tone_shaper.sv
module afsk_tone_shaper (
   input  logic [afsk_pkg::ADDR_BITS-1:0] index,
   input  logic                           emphasize,
   output afsk_pkg::sample_type           sample
);

   localparam afsk_pkg::sine_table_type SineTable = afsk_pkg::build_sine_table();

   afsk_pkg::sample_type raw;

   // Look up the sine and apply mark pre-emphasis
   always_comb begin
      raw = SineTable[index];
      if (emphasize) begin
         sample = (raw >> 1) + afsk_pkg::EMPH_OFFSET;
      end else begin
         sample = raw;
      end
   end

endmodule
